@@ design/uuid_text_parser_core_macros.svh @@
// Assertion macros shared by the UUID text parser modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef UUID_TEXT_PARSER_CORE_MACROS_SVH
`define UUID_TEXT_PARSER_CORE_MACROS_SVH

// The condition holds at every clock edge.
`define UUIDP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("uuidp invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define UUIDP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uuidp implication violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define UUIDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uuidp next-cycle implication violated");

`endif

@@ design/uuidp_pkg.sv @@
// Types, constants and the hex digit decoder for the UUID text parser.
// Used by uuidp_char_stage, uuidp_out_buf and uuid_text_parser_core.
`default_nettype none

package uuidp_pkg;

    // Character codes that steer the parse.
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;

    // Lengths and counts.
    localparam logic [5:0] BRACED_LEN = 6'd38;
    localparam logic [5:0] PLAIN_LEN  = 6'd36;
    localparam logic [5:0] INNER_LEN  = 6'd36;
    localparam logic [5:0] COUNT_MAX  = 6'd63;
    localparam logic [4:0] UUID_BYTES = 5'd16;

    // One input item: a character and its end-of-text flag.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [63:0] uuid_upper;
        logic [63:0] uuid_lower;
        logic        parse_ok;
    } out_item_t;

    // A result handed from the parse stage to the output buffer.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_push_t;

    // Decoded hex digit: valid flag and the 4-bit value.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII character as a hex digit in either case.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d.value = c[3:0] + 4'd9;
        end
        else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ design/uuid_text_parser_core.sv @@
// UUID text parser top level.
// Channels: char_valid/char_stall/char_item takes one ASCII character per item,
// with last_char marking the end of the text. res_valid/res_stall/res_item gives
// one result per text: the 128-bit value as two 64-bit halves and parse_ok.
// A text is 36 characters, or 38 when it opens with a brace and ends with one.
// Sixteen hex digit pairs in either case, each optionally followed by a dash.
// On any failure the value is zero and parse_ok is low.
// Throughput: one character per cycle while char_stall is low, set by the single
// parse stage whose state updates on every accepted item.
// A result is registered in the result register, or else in the skid entry.
// The result register has a skid entry behind it, so characters keep flowing
// while one result waits; char_stall rises only when both entries hold results.
// Reset clears the parse state and empties the output buffer.
// Depends on uuidp_pkg, uuidp_char_stage and uuidp_out_buf.
`default_nettype none

module uuid_text_parser_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  uuidp_pkg::in_item_t  char_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output uuidp_pkg::out_item_t res_item
);

    uuidp_pkg::res_push_t push;
    logic                 buf_full;

    assign char_stall = buf_full;

    // Per-character parse state and result formation.
    uuidp_char_stage u_char_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_item  (char_item),
        .char_stall (buf_full),
        .push       (push)
    );

    // Result register with skid entry.
    uuidp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

`default_nettype wire

@@ design/uuidp_char_stage.sv @@
// Parse stage: holds the per-text parse state and updates it on each item.
// Depends on uuidp_pkg and uuid_text_parser_core_macros.svh.
`default_nettype none
`include "uuid_text_parser_core_macros.svh"

module uuidp_char_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    input  uuidp_pkg::in_item_t  char_item,
    input  logic                 char_stall,
    output uuidp_pkg::res_push_t push
);

    logic [5:0]  char_count_reg;
    logic [5:0]  char_count_next;
    logic        braced_reg;
    logic        braced_next;
    logic [4:0]  bytes_done_reg;
    logic [4:0]  bytes_done_next;
    logic        low_nibble_reg;
    logic        low_nibble_next;
    logic [3:0]  high_nibble_reg;
    logic [3:0]  high_nibble_next;
    logic        dash_allowed_reg;
    logic        dash_allowed_next;
    logic        failed_reg;
    logic        failed_next;
    logic [63:0] upper_reg;
    logic [63:0] upper_next;
    logic [63:0] lower_reg;
    logic [63:0] lower_next;

    logic                  accept;
    logic [7:0]            c;
    logic                  inner_en;
    logic                  len_ok;
    logic                  ok;
    logic [7:0]            new_byte;
    uuidp_pkg::hex_digit_t hex;

    assign accept = char_valid && !char_stall;
    assign c      = char_item.char_code;
    assign hex    = uuidp_pkg::hex_decode(c);

    // Next parse state for the current character.
    always_comb
    begin
        braced_next       = (char_count_reg == 6'd0) ? (c == uuidp_pkg::CHAR_LBRACE)
                                                     : braced_reg;
        bytes_done_next   = bytes_done_reg;
        low_nibble_next   = low_nibble_reg;
        high_nibble_next  = high_nibble_reg;
        dash_allowed_next = dash_allowed_reg;
        failed_next       = failed_reg;
        upper_next        = upper_reg;
        lower_next        = lower_reg;
        new_byte          = {high_nibble_reg, hex.value};

        // The inside text follows the optional opening brace.
        if (braced_next) begin
            inner_en = (char_count_reg != 6'd0) && (char_count_reg <= uuidp_pkg::INNER_LEN);
        end
        else begin
            inner_en = (char_count_reg < uuidp_pkg::INNER_LEN);
        end

        if (inner_en && !failed_reg && (bytes_done_reg < uuidp_pkg::UUID_BYTES)) begin
            dash_allowed_next = 1'b0;
            if (dash_allowed_reg && (c == uuidp_pkg::CHAR_DASH)) begin
                // One optional dash after a byte is skipped.
                dash_allowed_next = 1'b0;
            end
            else if (!hex.valid) begin
                failed_next = 1'b1;
            end
            else if (!low_nibble_reg) begin
                high_nibble_next = hex.value;
                low_nibble_next  = 1'b1;
            end
            else begin
                // A byte is complete: shift it into its half of the value.
                if (!bytes_done_reg[3]) begin
                    upper_next = {upper_reg[55:0], new_byte};
                end
                else begin
                    lower_next = {lower_reg[55:0], new_byte};
                end
                bytes_done_next   = bytes_done_reg + 5'd1;
                low_nibble_next   = 1'b0;
                dash_allowed_next = 1'b1;
            end
        end

        // The character counter saturates.
        char_count_next = (char_count_reg == uuidp_pkg::COUNT_MAX) ? char_count_reg
                                                                  : char_count_reg + 6'd1;
    end

    // Final checks on the last character.
    always_comb
    begin
        if (braced_next) begin
            len_ok = (char_count_next == uuidp_pkg::BRACED_LEN) && (c == uuidp_pkg::CHAR_RBRACE);
        end
        else begin
            len_ok = (char_count_next == uuidp_pkg::PLAIN_LEN);
        end
        ok = len_ok && !failed_next && (bytes_done_next == uuidp_pkg::UUID_BYTES);
    end

    assign push.valid           = accept && char_item.last_char;
    assign push.item.uuid_upper = ok ? upper_next : 64'd0;
    assign push.item.uuid_lower = ok ? lower_next : 64'd0;
    assign push.item.parse_ok   = ok;

    // Parse state registers; the last character returns them to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_count_reg   <= 6'd0;
            braced_reg       <= 1'b0;
            bytes_done_reg   <= 5'd0;
            low_nibble_reg   <= 1'b0;
            high_nibble_reg  <= 4'd0;
            dash_allowed_reg <= 1'b0;
            failed_reg       <= 1'b0;
            upper_reg        <= 64'd0;
            lower_reg        <= 64'd0;
        end
        else if (accept) begin
            if (char_item.last_char) begin
                char_count_reg   <= 6'd0;
                braced_reg       <= 1'b0;
                bytes_done_reg   <= 5'd0;
                low_nibble_reg   <= 1'b0;
                high_nibble_reg  <= 4'd0;
                dash_allowed_reg <= 1'b0;
                failed_reg       <= 1'b0;
                upper_reg        <= 64'd0;
                lower_reg        <= 64'd0;
            end
            else begin
                char_count_reg   <= char_count_next;
                braced_reg       <= braced_next;
                bytes_done_reg   <= bytes_done_next;
                low_nibble_reg   <= low_nibble_next;
                high_nibble_reg  <= high_nibble_next;
                dash_allowed_reg <= dash_allowed_next;
                failed_reg       <= failed_next;
                upper_reg        <= upper_next;
                lower_reg        <= lower_next;
            end
        end
    end

    // Byte count never passes sixteen, and a half byte never waits after the last byte.
    `UUIDP_ASSERT_ALWAYS(a_bytes_bound, bytes_done_reg <= uuidp_pkg::UUID_BYTES)
    `UUIDP_ASSERT_IMPL(a_nibble_bytes, low_nibble_reg, bytes_done_reg < uuidp_pkg::UUID_BYTES)
    // A dash is only allowed between complete bytes.
    `UUIDP_ASSERT_IMPL(a_dash_nibble, dash_allowed_reg, !low_nibble_reg)
    // A result restarts the text.
    `UUIDP_ASSERT_NEXT(a_restart, push.valid, char_count_reg == 6'd0 && !failed_reg)

endmodule

`default_nettype wire

@@ design/uuidp_out_buf.sv @@
// Two-entry output buffer: result register plus a skid entry.
// Depends on uuidp_pkg and uuid_text_parser_core_macros.svh.
`default_nettype none
`include "uuid_text_parser_core_macros.svh"

module uuidp_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uuidp_pkg::res_push_t push,
    output logic                 full,
    output logic                 res_valid,
    input  logic                 res_stall,
    output uuidp_pkg::out_item_t res_item
);

    logic                 main_valid_reg;
    uuidp_pkg::out_item_t main_item_reg;
    logic                 skid_valid_reg;
    uuidp_pkg::out_item_t skid_item_reg;
    logic                 pop;

    assign pop       = main_valid_reg && !res_stall;
    assign res_valid = main_valid_reg;
    assign res_item  = main_item_reg;
    assign full      = skid_valid_reg;

    // Valid flags for both entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!main_valid_reg || pop) begin
            main_valid_reg <= push.valid;
        end
        else if (push.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Item payloads; the skid entry moves up when the result register drains.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_item_reg <= skid_item_reg;
            end
        end
        else if (!main_valid_reg || pop) begin
            if (push.valid) begin
                main_item_reg <= push.item;
            end
        end
        else if (push.valid) begin
            skid_item_reg <= push.item;
        end
    end

    // The skid entry is used only behind a full result register.
    `UUIDP_ASSERT_IMPL(a_skid_behind_main, skid_valid_reg, main_valid_reg)
    // A result that meets a stalled full register lands in the skid entry.
    `UUIDP_ASSERT_NEXT(a_skid_capture, main_valid_reg && res_stall && push.valid, skid_valid_reg)
    // No result arrives while both entries are full.
    `UUIDP_ASSERT_IMPL(a_no_overflow, skid_valid_reg, !push.valid)

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for uuid_text_parser_core: random and directed UUID texts,
// predicted in the bench and compared against every result item the block returns.
// Depends on uuidp_pkg for the item types and the character and length constants.

module tb;
    import uuidp_pkg::*;

    // Ways a well-formed text gets damaged in the random part.
    typedef enum int {
        DMG_RANDOM_CHAR,
        DMG_NEAR_HEX,
        DMG_DROP_CHAR,
        DMG_EXTRA_CHAR,
        DMG_EXTRA_DASH,
        DMG_LAST_CHAR,
        DMG_TRUNCATE,
        DMG_APPEND
    } damage_t;

    // Receiver stall patterns.
    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_MOST,
        STALL_ALTERNATE
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    in_item_t    char_item = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    out_item_t   res_item;

    // Stimulus and expectations.
    in_item_t    chars_to_send[$];
    out_item_t   expected_uuids[$];
    logic [7:0]  text_buf[$];
    int          chars_queued = 0;
    int          texts_queued = 0;
    int          chars_accepted = 0;
    int          mismatch_count = 0;
    logic        long_hold = 1'b0;

    // Bench copy of the parse state.
    logic [5:0]  text_len = '0;
    logic        opened_brace = 1'b0;
    logic [4:0]  bytes_seen = '0;
    logic        want_low = 1'b0;
    logic [3:0]  hi_nib = '0;
    logic        dash_ok = 1'b0;
    logic        parse_bad = 1'b0;
    logic [63:0] upper_acc = '0;
    logic [63:0] lower_acc = '0;

    // Sender pacing.
    int          burst_left = 0;
    int          gap_left = 0;
    bit          uuid_due;
    out_item_t   uuid_calc;

    // Receiver pacing.
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_span = 0;
    bit          want_stall;
    out_item_t   got_uuid;
    out_item_t   want_uuid;

    uuid_text_parser_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Return the bench copy of the parse state to the state it has between texts.
    task automatic clear_parse();
        text_len = '0;
        opened_brace = 1'b0;
        bytes_seen = '0;
        want_low = 1'b0;
        hi_nib = '0;
        dash_ok = 1'b0;
        parse_bad = 1'b0;
        upper_acc = '0;
        lower_acc = '0;
    endtask

    // Advance the parse by one character and return the result it ends with, if any.
    task automatic parse_char(input in_item_t it, output bit emitted, output out_item_t res);
        logic [5:0] pos;
        logic [7:0] c;
        logic [7:0] diff;
        logic [3:0] dig;
        bit         dig_ok;
        bit         in_inner;
        bit         ok;
        c = it.char_code;
        pos = text_len;
        emitted = 1'b0;
        res = '0;
        if (pos == 6'd0)
        begin
            opened_brace = (c == CHAR_LBRACE);
        end
        in_inner = opened_brace ? (pos >= 6'd1 && pos <= INNER_LEN) : (pos < INNER_LEN);

        // Inner text: hex pairs, each optionally followed by one dash.
        if (in_inner && !parse_bad && bytes_seen < UUID_BYTES)
        begin
            if (dash_ok && c == CHAR_DASH)
            begin
                dash_ok = 1'b0;
            end
            else
            begin
                dash_ok = 1'b0;
                dig_ok = 1'b1;
                if (c >= 8'h30 && c <= 8'h39)
                    diff = c - 8'h30;
                else if (c >= 8'h61 && c <= 8'h66)
                    diff = c - 8'h57;
                else if (c >= 8'h41 && c <= 8'h46)
                    diff = c - 8'h37;
                else
                begin
                    diff = 8'h00;
                    dig_ok = 1'b0;
                end
                dig = diff[3:0];
                if (!dig_ok)
                begin
                    parse_bad = 1'b1;
                end
                else if (!want_low)
                begin
                    hi_nib = dig;
                    want_low = 1'b1;
                end
                else
                begin
                    if (bytes_seen < 5'd8)
                        upper_acc = {upper_acc[55:0], hi_nib, dig};
                    else
                        lower_acc = {lower_acc[55:0], hi_nib, dig};
                    bytes_seen = bytes_seen + 5'd1;
                    want_low = 1'b0;
                    dash_ok = 1'b1;
                end
            end
        end

        // The length counter saturates.
        if (text_len != COUNT_MAX)
        begin
            text_len = text_len + 6'd1;
        end

        // The last character closes the text and yields its result.
        if (it.last_char)
        begin
            if (opened_brace)
                ok = (text_len == BRACED_LEN) && (c == CHAR_RBRACE);
            else
                ok = (text_len == PLAIN_LEN);
            ok = ok && !parse_bad && (bytes_seen == UUID_BYTES);
            emitted = 1'b1;
            res.parse_ok = ok;
            res.uuid_upper = ok ? upper_acc : 64'd0;
            res.uuid_lower = ok ? lower_acc : 64'd0;
            clear_parse();
        end
    endtask

    // A hex digit for a nibble, letters in random case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        else if ($urandom_range(0, 1) == 1)
            return 8'h37 + {4'h0, n};
        else
            return 8'h57 + {4'h0, n};
    endfunction

    // Characters just outside the hex digit ranges.
    function automatic logic [7:0] near_hex_code(input int k);
        case (k)
            0: return 8'h2F;
            1: return 8'h3A;
            2: return 8'h40;
            3: return 8'h47;
            4: return 8'h60;
            default: return 8'h67;
        endcase
    endfunction

    task automatic add_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
        begin
            text_buf.push_back(s[k]);
        end
    endtask

    // Build a text of the right shape with random bytes and a random dash layout.
    task automatic build_uuid(input bit with_braces);
        int         i;
        int         style;
        int         inner;
        logic [7:0] b;
        bit         dash;
        text_buf.delete();
        if (with_braces)
            text_buf.push_back(CHAR_LBRACE);
        style = $urandom_range(0, 3);
        for (i = 0; i < 16; i++)
        begin
            b = 8'($urandom_range(0, 255));
            text_buf.push_back(hex_char(b[7:4]));
            text_buf.push_back(hex_char(b[3:0]));
            if (style <= 1)
                dash = (i == 3 || i == 5 || i == 7 || i == 9);
            else if (style == 2)
                dash = 1'b0;
            else
                dash = ($urandom_range(0, 3) == 0);
            if (dash)
                text_buf.push_back(CHAR_DASH);
        end
        // Pad the inner text with characters the parser ignores.
        inner = text_buf.size() - (with_braces ? 1 : 0);
        while (inner < 36)
        begin
            text_buf.push_back(8'($urandom_range(0, 255)));
            inner++;
        end
        if (with_braces)
            text_buf.push_back(CHAR_RBRACE);
    endtask

    // Break a built text in one random way.
    task automatic damage_text();
        damage_t kind;
        int      idx;
        int      keep;
        int      n;
        kind = damage_t'($urandom_range(0, 7));
        idx = $urandom_range(0, text_buf.size() - 1);
        case (kind)
            DMG_RANDOM_CHAR: text_buf[idx] = 8'($urandom_range(0, 255));
            DMG_NEAR_HEX:    text_buf[idx] = near_hex_code($urandom_range(0, 5));
            DMG_DROP_CHAR:   text_buf.delete(idx);
            DMG_EXTRA_CHAR:  text_buf.insert(idx, 8'($urandom_range(0, 255)));
            DMG_EXTRA_DASH:  text_buf.insert(idx, CHAR_DASH);
            DMG_LAST_CHAR:   text_buf[text_buf.size() - 1] = 8'($urandom_range(0, 255));
            DMG_TRUNCATE:
            begin
                keep = $urandom_range(1, text_buf.size() - 1);
                while (text_buf.size() > keep)
                    text_buf.pop_back();
            end
            default:
            begin
                n = $urandom_range(1, 30);
                repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Queue the built text as items, flagging its final character.
    task automatic send_text();
        int       k;
        in_item_t it;
        for (k = 0; k < text_buf.size(); k++)
        begin
            it.char_code = text_buf[k];
            it.last_char = (k == text_buf.size() - 1);
            chars_to_send.push_back(it);
        end
        chars_queued += text_buf.size();
        texts_queued++;
        text_buf.delete();
    endtask

    // Sender: bursts of items from the pending queue with random gaps between them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            clear_parse();
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                parse_char(char_item, uuid_due, uuid_calc);
                if (uuid_due)
                    expected_uuids.push_back(uuid_calc);
                chars_accepted <= chars_accepted + 1;
            end
            if (!char_valid || !char_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    char_valid <= 1'b0;
                end
                else if (chars_to_send.size() > 0)
                begin
                    char_item <= chars_to_send.pop_front();
                    char_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(40, 120) : $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 6);
                    end
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result and drives its own stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                got_uuid = res_item;
                if (expected_uuids.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected uuid result: upper=%h lower=%h ok=%b",
                                 got_uuid.uuid_upper, got_uuid.uuid_lower,
                                 got_uuid.parse_ok);
                end
                else
                begin
                    want_uuid = expected_uuids.pop_front();
                    if (got_uuid.uuid_upper !== want_uuid.uuid_upper ||
                        got_uuid.uuid_lower !== want_uuid.uuid_lower ||
                        got_uuid.parse_ok !== want_uuid.parse_ok)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("uuid mismatch: expected %h %h %b, got %h %h %b",
                                     want_uuid.uuid_upper, want_uuid.uuid_lower,
                                     want_uuid.parse_ok, got_uuid.uuid_upper,
                                     got_uuid.uuid_lower, got_uuid.parse_ok);
                    end
                end
            end

            // Switch to a new random stall pattern when the current span runs out.
            if (stall_span == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_span = $urandom_range(16, 80);
            end
            else
            begin
                stall_span--;
            end
            case (stall_mode)
                STALL_NONE:  want_stall = 1'b0;
                STALL_HALF:  want_stall = ($urandom_range(0, 1) == 1);
                STALL_MOST:  want_stall = ($urandom_range(0, 3) != 0);
                default:     want_stall = ~res_stall;
            endcase
            res_stall <= long_hold || want_stall;
        end
    end

    // Long receiver hold-off in mid run, so both result entries fill and input stalls.
    initial
    begin
        @(posedge clk);
        while (chars_accepted < 800)
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Hard limit on the run time.
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    // Stimulus, then the wait for the last results and the verdict.
    initial
    begin
        int pick;
        int len;
        int k;

        // Directed texts: extremes, both layouts, and each failure case.
        add_str("00000000-0000-0000-0000-000000000000");
        send_text();
        add_str("FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF");
        send_text();
        add_str("{0123abcd-EF45-6789-aBcD-ef0123456789}");
        send_text();
        // No dashes; the trailing characters past the last byte are ignored.
        add_str("0123456789abcdefABCDEF0123456789");
        text_buf.push_back(8'h80);
        text_buf.push_back(8'hFF);
        add_str("-z");
        send_text();
        add_str("{00112233445566778899aabbccddeeffzzzz}");
        send_text();
        // Braced text with a wrong closing character.
        add_str("{00112233-4455-6677-8899-aabbccddeeff]");
        send_text();
        // Lengths one short of both forms and one or two past the plain form, all bytes present.
        add_str("{00112233445566778899aabbccddeeff---}");
        send_text();
        add_str("00112233445566778899aabbccddeeff---");
        send_text();
        add_str("00112233-4455-6677-8899-aabbccddeeff0");
        send_text();
        add_str("00112233-4455-6677-8899-aabbccddeeff}}");
        send_text();
        // Two dashes in a row, and a dash before the first byte.
        add_str("00112233--4455-677-8899-aabbccddeeff");
        send_text();
        add_str("-00112233445566778899aabbccddeeff-00");
        send_text();
        // A code above the ASCII range inside the text.
        add_str("00112233-4455-6677-8899-aabbccddeeff");
        text_buf[5] = 8'hC1;
        send_text();
        // Too many dashes leave bytes missing.
        add_str("00-11-22-33-44-55-66-77-88-99-aa-bb-");
        send_text();
        // One-character texts and a text long enough to saturate the counter.
        text_buf.push_back(CHAR_LBRACE);
        send_text();
        add_str("0");
        send_text();
        repeat (70) text_buf.push_back(8'h30);
        send_text();
        // Characters just outside the hex ranges.
        for (k = 0; k < 6; k++)
        begin
            build_uuid(k[0]);
            text_buf[k[0] ? 1 : 0] = near_hex_code(k);
            send_text();
        end

        // Random texts: mostly well formed, some damaged, some pure noise.
        while (chars_queued < 1150 || texts_queued < 30)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                build_uuid($urandom_range(0, 1) == 1);
                if (pick >= 55)
                    damage_text();
            end
            else
            begin
                len = $urandom_range(1, 70);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 1) == 1)
                        text_buf.push_back(hex_char(4'($urandom_range(0, 15))));
                    else
                        text_buf.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 2) == 0)
                    text_buf[0] = CHAR_LBRACE;
            end
            send_text();
        end

        // Release reset, then wait for every item and every expected result.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (chars_accepted != chars_queued)
            @(posedge clk);
        while (expected_uuids.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && expected_uuids.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
